FILE: design/mf3_pkg.sv
// shared types, constants and compare helpers for the 3x3 median filter
// no dependencies; imported by every module of the block
package mf3_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	// one column of three vertically adjacent samples
	typedef struct packed {
		sample_t upper;
		sample_t middle;
		sample_t lower;
	} column_t;

	// one window to be reduced to its median
	typedef struct packed {
		column_t left;
		column_t centre;
		column_t right;
		logic    last;
	} job_t;

	typedef struct packed {
		sample_t lo;
		sample_t mi;
		sample_t hi;
	} triple_t;

	function automatic sample_t min2(input sample_t a, input sample_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic sample_t max2(input sample_t a, input sample_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic sample_t min3(input sample_t a, input sample_t b, input sample_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic sample_t max3(input sample_t a, input sample_t b, input sample_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic triple_t sort3(input column_t col);
		triple_t t;
		t.lo = min3(col.upper, col.middle, col.lower);
		t.mi = med3(col.upper, col.middle, col.lower);
		t.hi = max3(col.upper, col.middle, col.lower);
		return t;
	endfunction

endpackage

FILE: design/mf3_front.sv
// front end: accepts columns, keeps the two previous columns and the row
// position, and turns each column into zero, one or two windows; uses mf3_pkg
module mf3_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             col_valid,
	output logic             col_ready,
	input  mf3_pkg::sample_t upper_sample,
	input  mf3_pkg::sample_t middle_sample,
	input  mf3_pkg::sample_t lower_sample,
	input  logic             row_end,
	input  logic             queue_full,
	output logic             push,
	output mf3_pkg::job_t    push_job
);
	import mf3_pkg::*;

	column_t    older_q;
	column_t    newer_q;
	logic [1:0] seen_q;
	logic       pend_q;
	job_t       pend_job_q;

	column_t cur;
	job_t    job_a;
	logic    accept;
	logic    push_a;
	logic    row_start;

	assign cur.upper  = upper_sample;
	assign cur.middle = middle_sample;
	assign cur.lower  = lower_sample;

	assign col_ready = !pend_q && !queue_full;
	assign accept    = col_valid && col_ready;
	assign row_start = (seen_q == 2'd0);

	always_comb begin
		job_a.right = cur;
		priority if (row_start) begin
			// one-column row: the column stands in for both neighbours
			job_a.left   = cur;
			job_a.centre = cur;
		end else if (seen_q == 2'd1) begin
			job_a.left   = newer_q;
			job_a.centre = newer_q;
		end else begin
			job_a.left   = older_q;
			job_a.centre = newer_q;
		end
		job_a.last = row_start;
	end

	assign push_a   = accept && (!row_start || row_end);
	assign push     = push_a || (pend_q && !queue_full);
	assign push_job = pend_q ? pend_job_q : job_a;

	// right edge window is held and queued after the previous column's window
	always_ff @(posedge clk) begin
		if (accept && row_end && !row_start) begin
			pend_job_q.left   <= newer_q;
			pend_job_q.centre <= cur;
			pend_job_q.right  <= cur;
			pend_job_q.last   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			older_q <= '0;
			newer_q <= '0;
			seen_q  <= 2'd0;
		end else begin
			if (accept && row_end && !row_start) begin
				pend_q <= 1'b1;
			end else if (pend_q && !queue_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (row_end) begin
					seen_q <= 2'd0;
				end else if (row_start) begin
					newer_q <= cur;
					seen_q  <= 2'd1;
				end else begin
					older_q <= newer_q;
					newer_q <= cur;
					seen_q  <= 2'd2;
				end
			end
		end
	end

endmodule

FILE: design/mf3_queue.sv
// short window queue between front end and median pipeline
// uses mf3_pkg for the entry type and depth
module mf3_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mf3_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output mf3_pkg::job_t pop_job
);
	import mf3_pkg::*;

	job_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	localparam logic [QUEUE_AW:0]   FULL_COUNT = (QUEUE_AW+1)'(QUEUE_DEPTH);
	localparam logic [QUEUE_AW-1:0] LAST_PTR   = QUEUE_AW'(QUEUE_DEPTH - 1);

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/mf3_back.sv
// median pipeline: sort each column, reduce to max-of-lows, median-of-mids
// and min-of-highs, then take their median into the output register; uses mf3_pkg
module mf3_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_avail,
	input  mf3_pkg::job_t    job,
	output logic             job_pop,
	output logic             res_valid,
	input  logic             res_ready,
	output mf3_pkg::sample_t median_value,
	output logic             last_of_row
);
	import mf3_pkg::*;

	triple_t left_s1;
	triple_t centre_s1;
	triple_t right_s1;
	logic    last_s1;
	logic    valid_s1;

	sample_t lo_max_s2;
	sample_t mid_med_s2;
	sample_t hi_min_s2;
	logic    last_s2;
	logic    valid_s2;

	sample_t median_q;
	logic    last_q;
	logic    valid_q;

	logic advance;

	// whole pipeline moves together; it holds only while a result is stalled
	assign advance = !valid_q || res_ready;
	assign job_pop = advance && job_avail;

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s1    <= sort3(job.left);
			centre_s1  <= sort3(job.centre);
			right_s1   <= sort3(job.right);
			last_s1    <= job.last;
			lo_max_s2  <= max3(left_s1.lo, centre_s1.lo, right_s1.lo);
			mid_med_s2 <= med3(left_s1.mi, centre_s1.mi, right_s1.mi);
			hi_min_s2  <= min3(left_s1.hi, centre_s1.hi, right_s1.hi);
			last_s2    <= last_s1;
			median_q   <= med3(lo_max_s2, mid_med_s2, hi_min_s2);
			last_q     <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= job_avail;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	assign res_valid    = valid_q;
	assign median_value = median_q;
	assign last_of_row  = last_q;

endmodule

FILE: design/median_filter_3x3_edge_replicate.sv
// 3x3 median filter with edge replication, top level
// joins mf3_front, mf3_queue and mf3_back; uses mf3_pkg
//
// Input channel (col_valid/col_ready): one beat is one column of three
// vertically adjacent signed samples, plus row_end on the last column of
// a row. Output channel (res_valid/res_ready): one beat is the median of
// the 3x3 window around one column, with last_of_row on the row's final one.
// The first column of a row gives no result; every later column gives the
// result for the column before it; the row_end column adds the result for
// itself with the edge column repeated. A one-column row gives one result.
// A window passes through the queue, then the s1 sort, s2 reduce and output
// registers; a row_end column's second window follows the first.
// Throughput: one column per cycle while col_ready is high, and one result per
// cycle while res_ready is high; a two-result row_end column drops col_ready.
// Reset clears the stored columns and starts a new row.
// A stalled receiver holds the median pipeline; the four-entry window queue
// keeps taking columns until it fills, then col_ready drops.
module median_filter_3x3_edge_replicate (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             col_valid,
	output logic             col_ready,
	input  mf3_pkg::sample_t upper_sample,
	input  mf3_pkg::sample_t middle_sample,
	input  mf3_pkg::sample_t lower_sample,
	input  logic             row_end,
	output logic             res_valid,
	input  logic             res_ready,
	output mf3_pkg::sample_t median_value,
	output logic             last_of_row
);
	import mf3_pkg::*;

	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic not_empty;
	job_t pop_job;

	mf3_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.col_valid     (col_valid),
		.col_ready     (col_ready),
		.upper_sample  (upper_sample),
		.middle_sample (middle_sample),
		.lower_sample  (lower_sample),
		.row_end       (row_end),
		.queue_full    (queue_full),
		.push          (push),
		.push_job      (push_job)
	);

	mf3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_job   (pop_job)
	);

	mf3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_avail    (not_empty),
		.job          (pop_job),
		.job_pop      (pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.median_value (median_value),
		.last_of_row  (last_of_row)
	);

endmodule
